### hw/rtl/vgbm_pkg.sv
// ----------------------------------------------------------------------------
// vgbm_pkg
// shared constants and types for the greedy voxel box merger
// ----------------------------------------------------------------------------
package vgbm_pkg;

    // default grid geometry
    localparam int GRID_SIDE_DEF  = 16;
    localparam int TYPE_COUNT_DEF = 3;

    // field widths fixed by the stream format
    localparam int COORD_W = 4;
    localparam int VTYPE_W = 2;
    localparam int OP_W    = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_NEXT  = 2'd2;

    // one result beat
    typedef struct packed {
        logic               box_valid;
        logic               scan_done;
        logic [VTYPE_W-1:0] box_type;
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] min_z;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] max_y;
        logic [COORD_W-1:0] max_z;
    } t_box_result;

endpackage

### hw/rtl/voxel_greedy_box_merge.sv
// ----------------------------------------------------------------------------
// voxel_greedy_box_merge
// greedy box merging over a cubic voxel grid held in two rams
//
//  channel  dir  beat content
//  s_axis   in   tuser: operation; tdata: cell x, y, z, voxel type
//  m_axis   out  tuser: box valid, scan done; tdata: box type and corners
//
// a voxel write or an unused operation goes straight to the result beat, a start
// runs the sweep over all cells that rebuilds the free mask
// a box request scans cells, changes pass, probes cells and clears row or
// plane cells, each probe waiting on the registered read at the one read
// address that the two rams share
// after reset a clearing pass over all GRID_SIDE**3 cells runs with tready low
// a new beat is taken while the last result still waits on m_axis
// ----------------------------------------------------------------------------
module voxel_greedy_box_merge #(
    parameter int GRID_SIDE  = vgbm_pkg::GRID_SIDE_DEF,
    parameter int TYPE_COUNT = vgbm_pkg::TYPE_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // x[3:0], y[7:4], z[11:8], cell type[13:12], zero[15:14]
    input  logic [15:0] i_s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // box_type[1:0], min_x[5:2], min_y[9:6], min_z[13:10],
    // max_x[17:14], max_y[21:18], max_z[25:22], zero[31:26]
    output logic [31:0] o_m_axis_tdata,
    // box_valid[0], scan_done[1]
    output logic [1:0]  o_m_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready
);
    import vgbm_pkg::*;

    localparam int CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(GRID_SIDE);
    localparam int TPW   = $clog2(TYPE_COUNT + 1);
    localparam logic [CW-1:0] CMAX = CW'(GRID_SIDE - 1);

    // state codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_SWEEP = 4'd2;
    localparam logic [3:0] S_SRD   = 4'd3;
    localparam logic [3:0] S_SCK   = 4'd4;
    localparam logic [3:0] S_XRD   = 4'd5;
    localparam logic [3:0] S_XCK   = 4'd6;
    localparam logic [3:0] S_ZRD   = 4'd7;
    localparam logic [3:0] S_ZCK   = 4'd8;
    localparam logic [3:0] S_ZCL   = 4'd9;
    localparam logic [3:0] S_YRD   = 4'd10;
    localparam logic [3:0] S_YCK   = 4'd11;
    localparam logic [3:0] S_YCL   = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    function automatic logic [AW-1:0] f_addr(input logic [CW-1:0] x,
                                             input logic [CW-1:0] y,
                                             input logic [CW-1:0] z);
        int v;
        v = (int'(y) * GRID_SIDE + int'(z)) * GRID_SIDE + int'(x);
        return AW'(v);
    endfunction

    logic [3:0]    r_state, n_state;
    logic [AW:0]   r_cnt, n_cnt;
    logic [TPW-1:0] r_pass, n_pass;
    logic [CW-1:0] r_cx, r_cy, r_cz, n_cx, n_cy, n_cz;
    logic          r_cend, n_cend;
    logic [CW-1:0] r_bx, r_by, r_bz, n_bx, n_by, n_bz;
    logic [CW-1:0] r_xe, r_ye, r_ze, n_xe, n_ye, n_ze;
    logic [CW-1:0] r_px, r_py, r_pz, n_px, n_py, n_pz;
    logic [TPW-1:0] r_t, n_t;
    t_box_result   r_res, n_res, r_out, n_out;
    logic          r_ov, n_ov;

    logic          w_ty_we, w_fr_we, w_fr_wd;
    logic [AW-1:0] w_ty_wa, w_fr_wa, w_raddr;
    logic [VTYPE_W-1:0] w_ty_wd, w_ty_rd;
    logic          w_fr_rd;
    logic          w_join, w_hit, w_accept;
    logic [CW-1:0] w_in_x, w_in_y, w_in_z;
    logic          w_in_range;

    // input beat fields
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_x     = CW'(i_s_axis_tdata[3:0]);
    assign w_in_y     = CW'(i_s_axis_tdata[7:4]);
    assign w_in_z     = CW'(i_s_axis_tdata[11:8]);
    assign w_in_range = (int'(i_s_axis_tdata[3:0]) < GRID_SIDE)
                     && (int'(i_s_axis_tdata[7:4]) < GRID_SIDE)
                     && (int'(i_s_axis_tdata[11:8]) < GRID_SIDE);

    // cell match against the probed ram data
    assign w_join = w_fr_rd && (TPW'(w_ty_rd) == r_t);
    assign w_hit  = w_fr_rd && (TPW'(w_ty_rd) == r_pass);

    // voxel type store
    vgbm_ram #(.WIDTH(VTYPE_W), .DEPTH(CELLS)) u_type_ram (
        .i_clk   (i_clk),
        .i_we    (w_ty_we),
        .i_waddr (w_ty_wa),
        .i_wdata (w_ty_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_ty_rd)
    );

    // free mask
    vgbm_ram #(.WIDTH(1), .DEPTH(CELLS)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (w_fr_we),
        .i_waddr (w_fr_wa),
        .i_wdata (w_fr_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_fr_rd)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tuser  = {r_out.scan_done, r_out.box_valid};
    assign o_m_axis_tdata  = {6'd0, r_out.max_z, r_out.max_y, r_out.max_x,
                              r_out.min_z, r_out.min_y, r_out.min_x, r_out.box_type};

    // sequencer and ram port control
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pass  = r_pass;
        n_cx = r_cx; n_cy = r_cy; n_cz = r_cz; n_cend = r_cend;
        n_bx = r_bx; n_by = r_by; n_bz = r_bz;
        n_xe = r_xe; n_ye = r_ye; n_ze = r_ze;
        n_px = r_px; n_py = r_py; n_pz = r_pz;
        n_t   = r_t;
        n_res = r_res;
        n_out = r_out;
        n_ov  = r_ov;
        w_ty_we = 1'b0;
        w_ty_wa = f_addr(w_in_x, w_in_y, w_in_z);
        w_ty_wd = i_s_axis_tdata[13:12];
        w_fr_we = 1'b0;
        w_fr_wa = f_addr(r_px, r_py, r_pz);
        w_fr_wd = 1'b0;
        w_raddr = f_addr(r_px, r_py, r_pz);

        // result beat leaves
        if (r_ov && i_m_axis_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                w_ty_we = 1'b1;
                w_ty_wa = r_cnt[AW-1:0];
                w_ty_wd = '0;
                w_fr_we = 1'b1;
                w_fr_wa = r_cnt[AW-1:0];
                if (r_cnt == (AW+1)'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
                n_cnt = r_cnt + 1'b1;
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_res = '0;
                    case (i_s_axis_tuser)
                        OP_WRITE: begin
                            w_ty_we = w_in_range;
                            n_state = S_DONE;
                        end
                        OP_START: begin
                            n_cnt  = '0;
                            n_pass = '0;
                            n_cx = '0; n_cy = '0; n_cz = '0; n_cend = 1'b0;
                            n_state = S_SWEEP;
                        end
                        OP_NEXT: begin
                            n_state = S_SRD;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                // read cell cnt, write free bit of cell cnt-1
                w_raddr = r_cnt[AW-1:0];
                w_fr_we = (r_cnt != '0);
                w_fr_wa = AW'(r_cnt - 1'b1);
                w_fr_wd = (w_ty_rd != '0);
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == (AW+1)'(CELLS)) begin
                    n_state = S_DONE;
                end
            end
            S_SRD: begin
                w_raddr = f_addr(r_cx, r_cy, r_cz);
                if (int'(r_pass) >= TYPE_COUNT) begin
                    n_res.scan_done = 1'b1;
                    n_state = S_DONE;
                end else if (r_cend) begin
                    n_pass = r_pass + 1'b1;
                    n_cend = 1'b0;
                    n_cx = '0; n_cy = '0; n_cz = '0;
                end else begin
                    n_state = S_SCK;
                end
            end
            S_SCK: begin
                // step the cursor in x, z, y order
                if (r_cx == CMAX) begin
                    n_cx = '0;
                    if (r_cz == CMAX) begin
                        n_cz = '0;
                        if (r_cy == CMAX) begin
                            n_cy   = '0;
                            n_cend = 1'b1;
                        end else begin
                            n_cy = r_cy + 1'b1;
                        end
                    end else begin
                        n_cz = r_cz + 1'b1;
                    end
                end else begin
                    n_cx = r_cx + 1'b1;
                end
                if (w_hit) begin
                    w_fr_we = 1'b1;
                    w_fr_wa = f_addr(r_cx, r_cy, r_cz);
                    n_t  = r_pass;
                    n_bx = r_cx; n_by = r_cy; n_bz = r_cz;
                    n_xe = r_cx; n_ye = r_cy; n_ze = r_cz;
                    n_py = r_cy; n_pz = r_cz;
                    n_px = r_cx + 1'b1;
                    if (r_cx == CMAX) begin
                        // no room along x, go to rows
                        if (r_cz == CMAX) begin
                            if (r_cy == CMAX) begin
                                n_state = S_DONE;
                                n_res.box_valid = 1'b1;
                            end else begin
                                n_px = r_cx; n_pz = r_cz; n_py = r_cy + 1'b1;
                                n_state = S_YRD;
                            end
                        end else begin
                            n_px = r_cx; n_pz = r_cz + 1'b1;
                            n_state = S_ZRD;
                        end
                    end else begin
                        n_state = S_XRD;
                    end
                    n_res.box_type = 2'(r_pass);
                    n_res.min_x = 4'(r_cx); n_res.max_x = 4'(r_cx);
                    n_res.min_y = 4'(r_cy); n_res.max_y = 4'(r_cy);
                    n_res.min_z = 4'(r_cz); n_res.max_z = 4'(r_cz);
                    if (r_cx == CMAX && r_cz == CMAX && r_cy == CMAX) begin
                        n_res.box_valid = 1'b1;
                    end
                end else begin
                    n_state = S_SRD;
                end
            end
            S_XRD, S_ZRD, S_YRD: begin
                n_state = r_state + 1'b1;
            end
            S_XCK: begin
                if (w_join) begin
                    w_fr_we = 1'b1;
                    n_xe = r_px;
                    n_res.max_x = 4'(r_px);
                end
                if (w_join && r_px != CMAX) begin
                    n_px = r_px + 1'b1;
                    n_state = S_XRD;
                end else if (r_bz != CMAX) begin
                    n_px = r_bx; n_pz = r_bz + 1'b1;
                    n_state = S_ZRD;
                end else if (r_by != CMAX) begin
                    n_px = r_bx; n_pz = r_bz; n_py = r_by + 1'b1;
                    n_state = S_YRD;
                end else begin
                    n_res.box_valid = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_ZCK: begin
                if (w_join) begin
                    if (r_px == r_xe) begin
                        n_px = r_bx;
                        n_state = S_ZCL;
                    end else begin
                        n_px = r_px + 1'b1;
                        n_state = S_ZRD;
                    end
                end else if (r_by != CMAX) begin
                    n_px = r_bx; n_pz = r_bz; n_py = r_by + 1'b1;
                    n_state = S_YRD;
                end else begin
                    n_res.box_valid = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_ZCL: begin
                w_fr_we = 1'b1;
                if (r_px == r_xe) begin
                    n_ze = r_pz;
                    n_res.max_z = 4'(r_pz);
                    n_px = r_bx;
                    if (r_pz != CMAX) begin
                        n_pz = r_pz + 1'b1;
                        n_state = S_ZRD;
                    end else if (r_by != CMAX) begin
                        n_pz = r_bz; n_py = r_by + 1'b1;
                        n_state = S_YRD;
                    end else begin
                        n_res.box_valid = 1'b1;
                        n_state = S_DONE;
                    end
                end else begin
                    n_px = r_px + 1'b1;
                end
            end
            S_YCK: begin
                if (w_join) begin
                    if (r_px == r_xe) begin
                        n_px = r_bx;
                        if (r_pz == r_ze) begin
                            n_pz = r_bz;
                            n_state = S_YCL;
                        end else begin
                            n_pz = r_pz + 1'b1;
                            n_state = S_YRD;
                        end
                    end else begin
                        n_px = r_px + 1'b1;
                        n_state = S_YRD;
                    end
                end else begin
                    n_res.box_valid = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_YCL: begin
                w_fr_we = 1'b1;
                if (r_px == r_xe) begin
                    n_px = r_bx;
                    if (r_pz == r_ze) begin
                        n_pz = r_bz;
                        n_ye = r_py;
                        n_res.max_y = 4'(r_py);
                        if (r_py != CMAX) begin
                            n_py = r_py + 1'b1;
                            n_state = S_YRD;
                        end else begin
                            n_res.box_valid = 1'b1;
                            n_state = S_DONE;
                        end
                    end else begin
                        n_pz = r_pz + 1'b1;
                    end
                end else begin
                    n_px = r_px + 1'b1;
                end
            end
            S_DONE: begin
                // hand the result to the output register once it is free
                if (!r_ov || i_m_axis_tready) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_pass  <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_cz    <= '0;
            r_cend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pass  <= n_pass;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_cz    <= n_cz;
            r_cend  <= n_cend;
            r_ov    <= n_ov;
        end
    end

    // box and result payload
    always_ff @(posedge i_clk) begin
        r_bx  <= n_bx;
        r_by  <= n_by;
        r_bz  <= n_bz;
        r_xe  <= n_xe;
        r_ye  <= n_ye;
        r_ze  <= n_ze;
        r_px  <= n_px;
        r_py  <= n_py;
        r_pz  <= n_pz;
        r_t   <= n_t;
        r_res <= n_res;
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    // box extents never fall below the seed corner while growing
    a_extent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ZCL || r_state == S_YCL || r_state == S_YCK)
        |-> (r_xe >= r_bx && r_ze >= r_bz && r_ye >= r_by))
        else $error("box extent below seed corner");

    // row clear stays inside the x run
    a_row_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ZCL || r_state == S_YCL) |-> (r_px >= r_bx && r_px <= r_xe))
        else $error("clear outside x run");

    // a result never carries a box and done together
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !(r_out.box_valid && r_out.scan_done))
        else $error("box and done both set");

    // no beat taken during the clearing pass or the sweep
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR || r_state == S_SWEEP) |-> !o_s_axis_tready)
        else $error("ready while sweeping");
`endif

endmodule

### hw/rtl/vgbm_ram.sv
// ----------------------------------------------------------------------------
// vgbm_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module vgbm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same address write
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
